### design/max_cut_segments_dp_defines.svh
`ifndef MAX_CUT_SEGMENTS_DP_DEFINES_SVH
`define MAX_CUT_SEGMENTS_DP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define MCSDP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define MCSDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/mcsdp_pkg.sv
package mcsdp_pkg;

	localparam int FIELD_W     = 12;
	localparam int MAX_LEN_DEF = 4095;
	localparam int LANES       = 3;

	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_INIT,
		STEP_LOOP,
		STEP_DRAIN,
		STEP_DONE
	} step_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_START,
		COND_SHORT,
		COND_LAST,
		COND_ALWAYS
	} cond_t;

	typedef struct packed {
		logic  load;   // open for a new request
		logic  init;   // write entry zero if rod_length is in range, clear result
		logic  issue;  // issue table reads for the current position
		logic  emit;   // present the result
		cond_t cond;
		step_t jump;   // taken when cond holds
		step_t next;   // taken otherwise
	} ucode_t;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '{load: 1'b1, init: 1'b0, issue: 1'b0, emit: 1'b0,
		      cond: COND_START, jump: STEP_INIT, next: STEP_IDLE};
		case (s)
			STEP_IDLE: begin
				w = '{load: 1'b1, init: 1'b0, issue: 1'b0, emit: 1'b0,
				      cond: COND_START, jump: STEP_INIT, next: STEP_IDLE};
			end
			STEP_INIT: begin
				w = '{load: 1'b0, init: 1'b1, issue: 1'b0, emit: 1'b0,
				      cond: COND_SHORT, jump: STEP_DONE, next: STEP_LOOP};
			end
			STEP_LOOP: begin
				w = '{load: 1'b0, init: 1'b0, issue: 1'b1, emit: 1'b0,
				      cond: COND_LAST, jump: STEP_DRAIN, next: STEP_LOOP};
			end
			STEP_DRAIN: begin
				w = '{load: 1'b0, init: 1'b0, issue: 1'b0, emit: 1'b0,
				      cond: COND_ALWAYS, jump: STEP_DONE, next: STEP_DONE};
			end
			STEP_DONE: begin
				w = '{load: 1'b0, init: 1'b0, issue: 1'b0, emit: 1'b1,
				      cond: COND_ALWAYS, jump: STEP_IDLE, next: STEP_IDLE};
			end
			default: begin
				w = '{load: 1'b0, init: 1'b0, issue: 1'b0, emit: 1'b0,
				      cond: COND_ALWAYS, jump: STEP_IDLE, next: STEP_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

### design/mcsdp_ram.sv
module mcsdp_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### design/max_cut_segments_dp.sv
// Greatest number of pieces, each of length piece_a, piece_b or piece_c, that fill rod_length
// exactly (zero if none do). A request is taken when start is high and busy is low. The table
// is filled one entry per cycle, from length 1 up to rod_length, through three copies of the
// table, each written with every entry and read once a cycle. busy stays high through the
// init, loop, drain and done steps (only init and done when rod_length is 0 or over MAX_LEN).
// done is high for exactly one cycle, the last busy cycle, with max_segments valid alongside;
// the receiver cannot stall it, so sample it then. No clearing is needed after reset.
`include "max_cut_segments_dp_defines.svh"

module max_cut_segments_dp #(
	parameter int MAX_LEN = mcsdp_pkg::MAX_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mcsdp_pkg::FIELD_W-1:0] rod_length,
	input  logic [mcsdp_pkg::FIELD_W-1:0] piece_a,
	input  logic [mcsdp_pkg::FIELD_W-1:0] piece_b,
	input  logic [mcsdp_pkg::FIELD_W-1:0] piece_c,
	output logic                         busy,
	output logic                         done,
	output logic [mcsdp_pkg::FIELD_W-1:0] max_segments
);

	localparam int FW    = mcsdp_pkg::FIELD_W;
	localparam int NL    = mcsdp_pkg::LANES;
	localparam int DEPTH = MAX_LEN + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = AW + 1;           // valid bit over count
	localparam int CMPW  = (AW > FW) ? AW : FW;

	mcsdp_pkg::step_t  step_q;
	mcsdp_pkg::ucode_t ctl;
	logic              take;
	logic              accept;

	logic [FW-1:0]   len_q;
	logic [FW-1:0]   piece_q [NL];
	logic [AW-1:0]   pos_q;
	logic [FW-1:0]   res_q;
	logic [EW-1:0]   last_wr_q;

	logic            valid_s1;
	logic [AW-1:0]   pos_s1;
	logic            last_s1;
	logic [NL-1:0]   en_s1;
	logic [NL-1:0]   fwd_s1;

	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] len_ext;
	logic            in_range;
	logic            short_len;
	logic            at_last;

	logic [NL-1:0]   en_c;
	logic [NL-1:0]   fwd_c;
	logic [AW-1:0]   rd_addr [NL];
	logic [EW-1:0]   rd_data [NL];
	logic [EW-1:0]   ent     [NL];

	logic            found;
	logic [AW-1:0]   best;
	logic [EW-1:0]   entry_c;
	logic [CMPW-1:0] best_ext;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [EW-1:0]   wr_data;

	assign ctl    = mcsdp_pkg::ucode_rom(step_q);
	assign busy   = !ctl.load;
	assign accept = ctl.load && start;
	assign done   = ctl.emit;
	assign max_segments = res_q;

	assign pos_ext   = CMPW'(pos_q);
	assign len_ext   = CMPW'(len_q);
	assign in_range  = len_ext <= CMPW'(MAX_LEN);
	assign short_len = !in_range || (len_q == '0);
	assign at_last   = pos_ext == len_ext;

	always_comb begin
		case (ctl.cond)
			mcsdp_pkg::COND_START:  take = start;
			mcsdp_pkg::COND_SHORT:  take = short_len;
			mcsdp_pkg::COND_LAST:   take = at_last;
			mcsdp_pkg::COND_ALWAYS: take = 1'b1;
			default:                take = 1'b0;
		endcase
	end

	// Read side: one lane per piece length, each on its own table copy
	for (genvar g = 0; g < NL; g++) begin : g_lane
		logic [CMPW-1:0] piece_ext;
		logic [CMPW-1:0] diff;

		assign piece_ext  = CMPW'(piece_q[g]);
		assign diff       = pos_ext - piece_ext;
		assign en_c[g]    = (piece_q[g] != '0) && (piece_ext <= pos_ext);
		assign rd_addr[g] = diff[AW-1:0];
		// The entry written this cycle is not yet visible to the read: take it from last_wr_q
		assign fwd_c[g]   = valid_s1 && (rd_addr[g] == pos_s1);
		assign ent[g]     = fwd_s1[g] ? last_wr_q : rd_data[g];

		mcsdp_ram #(
			.WIDTH(EW),
			.DEPTH(DEPTH)
		) u_table (
			.clk    (clk),
			.wr_en  (wr_en),
			.wr_addr(wr_addr),
			.wr_data(wr_data),
			.rd_addr(rd_addr[g]),
			.rd_data(rd_data[g])
		);
	end

	// Best reachable predecessor, plus one
	always_comb begin
		logic [AW-1:0] cand;
		found = 1'b0;
		best  = '0;
		for (int i = 0; i < NL; i++) begin
			cand = ent[i][AW-1:0] + AW'(1);
			if (en_s1[i] && ent[i][AW]) begin
				if (!found || (cand > best)) begin
					best = cand;
				end
				found = 1'b1;
			end
		end
		entry_c  = found ? {1'b1, best} : '0;
		best_ext = CMPW'(best);
	end

	assign wr_en   = valid_s1 || (ctl.init && in_range);
	assign wr_addr = valid_s1 ? pos_s1 : '0;
	assign wr_data = valid_s1 ? entry_c : {1'b1, {AW{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= mcsdp_pkg::STEP_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			step_q   <= take ? ctl.jump : ctl.next;
			valid_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_q      <= rod_length;
			piece_q[0] <= piece_a;
			piece_q[1] <= piece_b;
			piece_q[2] <= piece_c;
		end
		if (ctl.init) begin
			pos_q <= AW'(1);
			res_q <= '0;
		end
		if (ctl.issue) begin
			pos_q <= pos_q + AW'(1);
		end
		pos_s1  <= pos_q;
		last_s1 <= at_last;
		en_s1   <= en_c;
		fwd_s1  <= fwd_c;
		if (wr_en) begin
			last_wr_q <= wr_data;
		end
		if (valid_s1 && last_s1) begin
			res_q <= found ? best_ext[FW-1:0] : '0;
		end
	end

	`MCSDP_ASSERT_NEXT(a_accept_busy, accept, busy, "request taken but busy did not rise")
	`MCSDP_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`MCSDP_ASSERT_NOW(a_done_busy, done, busy && !valid_s1, "done while table still filling")
	`MCSDP_ASSERT_NOW(a_pos_bound, ctl.issue, (pos_ext <= len_ext) && in_range && (pos_q != '0),
		"position ran past the rod length")
	`MCSDP_ASSERT_NOW(a_no_zero_rewrite, valid_s1, pos_s1 != '0, "loop wrote entry zero")

endmodule
